/* rtl/assert_macros.svh */
// Assertion macros used by the RTL top level to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond implies expr in the same cycle, outside reset.
`define VTBB_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("implication check failed");

// Check that cond implies expr in the next cycle, including across reset.
`define VTBB_ASSERT_NEXT(label, clk, cond, expr) \
   label: assert property (@(posedge clk) (cond) |=> (expr)) \
      else $error("next-cycle check failed");

`endif

/* rtl/vtbb_pkg.sv */
// Package with shared types, constants and arithmetic helpers for the vertex transform.
`timescale 1ns / 1ps
`default_nettype none

package vtbb_pkg;

   localparam int COORD_BITS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int COEF_BITS  = 32;
   localparam int REG_BITS   = 2 * COEF_BITS;
   localparam int IDX_BITS   = 3;
   localparam int NUM_ROWS   = 4;
   localparam int NUM_AXES   = 3;

   localparam int PROD_W = COORD_BITS + COEF_BITS;
   localparam int SUM_W  = PROD_W + 2;
   localparam int SH_W   = SUM_W - FRAC_BITS;

   localparam int REQ_DATA_W = ((4 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((10 * COORD_BITS + 7) / 8) * 8;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;

   localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << 16;

   localparam logic [IDX_BITS-1:0] REG_ROW0_LEFT  = 3'd0;
   localparam logic [IDX_BITS-1:0] REG_ROW0_RIGHT = 3'd1;
   localparam logic [IDX_BITS-1:0] REG_ROW1_LEFT  = 3'd2;
   localparam logic [IDX_BITS-1:0] REG_ROW1_RIGHT = 3'd3;
   localparam logic [IDX_BITS-1:0] REG_ROW2_LEFT  = 3'd4;
   localparam logic [IDX_BITS-1:0] REG_ROW2_RIGHT = 3'd5;
   localparam logic [IDX_BITS-1:0] REG_ROW3_LEFT  = 3'd6;
   localparam logic [IDX_BITS-1:0] REG_ROW3_RIGHT = 3'd7;

   typedef struct packed {
      logic                we;
      logic [IDX_BITS-1:0] index;
      logic [REG_BITS-1:0] data;
   } csr_write_type;

   typedef struct packed {
      logic [NUM_ROWS-1:0][COORD_BITS-1:0] coord;
      logic                                last;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic signed [PROD_W-1:0] mul_s(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COEF_BITS-1:0]  b
   );
      logic signed [PROD_W-1:0] ae;
      logic signed [PROD_W-1:0] be;
      ae = PROD_W'(a);
      be = PROD_W'(b);
      return ae * be;
   endfunction

   function automatic logic [COORD_BITS-1:0] shift_sat(input logic signed [SUM_W-1:0] s);
      logic [SH_W-1:0]       sh;
      logic [COORD_BITS-1:0] res;
      sh = s[SUM_W-1:FRAC_BITS];
      if ((&sh[SH_W-1:COORD_BITS-1]) || !(|sh[SH_W-1:COORD_BITS-1])) begin
         res = sh[COORD_BITS-1:0];
      end else if (sh[SH_W-1]) begin
         res = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
         res = {1'b0, {(COORD_BITS-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* rtl/vtbb_front.sv */
// Front end: matrix registers and the pipelined 4x4 multiply, sum and saturate.
`timescale 1ns / 1ps
`default_nettype none

module vtbb_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire vtbb_pkg::csr_write_type     csr,
   input  wire                              in_valid,
   output logic                             in_ready,
   input  wire [vtbb_pkg::REQ_DATA_W-1:0]   in_data,
   input  wire                              in_last,
   input  wire vtbb_pkg::queue_status_type  q_status,
   output logic                             push,
   output vtbb_pkg::entry_type              push_entry
);

   logic [vtbb_pkg::REG_BITS-1:0] row_left_ff  [vtbb_pkg::NUM_ROWS];
   logic [vtbb_pkg::REG_BITS-1:0] row_right_ff [vtbb_pkg::NUM_ROWS];
   logic [vtbb_pkg::REG_BITS-1:0] row_left_in  [vtbb_pkg::NUM_ROWS];
   logic [vtbb_pkg::REG_BITS-1:0] row_right_in [vtbb_pkg::NUM_ROWS];

   logic signed [vtbb_pkg::COEF_BITS-1:0]  coef [vtbb_pkg::NUM_ROWS][4];
   logic signed [vtbb_pkg::COORD_BITS-1:0] p    [4];

   logic signed [vtbb_pkg::PROD_W-1:0] prod_ff [vtbb_pkg::NUM_ROWS][4];
   logic signed [vtbb_pkg::PROD_W-1:0] prod_in [vtbb_pkg::NUM_ROWS][4];
   logic signed [vtbb_pkg::SUM_W-1:0]  sum_ff  [vtbb_pkg::NUM_ROWS];
   logic signed [vtbb_pkg::SUM_W-1:0]  sum_in  [vtbb_pkg::NUM_ROWS];

   logic v1_ff, v1_in, last1_ff;
   logic v2_ff, v2_in, last2_ff;
   logic adv;

   // hold configuration writes
   always_comb begin
      for (int r = 0; r < vtbb_pkg::NUM_ROWS; r++) begin
         row_left_in[r]  = row_left_ff[r];
         row_right_in[r] = row_right_ff[r];
      end
      if (csr.we) begin
         case (csr.index)
            vtbb_pkg::REG_ROW0_LEFT:  row_left_in[0]  = csr.data;
            vtbb_pkg::REG_ROW0_RIGHT: row_right_in[0] = csr.data;
            vtbb_pkg::REG_ROW1_LEFT:  row_left_in[1]  = csr.data;
            vtbb_pkg::REG_ROW1_RIGHT: row_right_in[1] = csr.data;
            vtbb_pkg::REG_ROW2_LEFT:  row_left_in[2]  = csr.data;
            vtbb_pkg::REG_ROW2_RIGHT: row_right_in[2] = csr.data;
            vtbb_pkg::REG_ROW3_LEFT:  row_left_in[3]  = csr.data;
            vtbb_pkg::REG_ROW3_RIGHT: row_right_in[3] = csr.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_left_ff[0]  <= {vtbb_pkg::COEF_ONE, {vtbb_pkg::COEF_BITS{1'b0}}};
         row_left_ff[1]  <= {{vtbb_pkg::COEF_BITS{1'b0}}, vtbb_pkg::COEF_ONE};
         row_left_ff[2]  <= '0;
         row_left_ff[3]  <= '0;
         row_right_ff[0] <= '0;
         row_right_ff[1] <= '0;
         row_right_ff[2] <= {vtbb_pkg::COEF_ONE, {vtbb_pkg::COEF_BITS{1'b0}}};
         row_right_ff[3] <= {{vtbb_pkg::COEF_BITS{1'b0}}, vtbb_pkg::COEF_ONE};
      end else begin
         for (int r = 0; r < vtbb_pkg::NUM_ROWS; r++) begin
            row_left_ff[r]  <= row_left_in[r];
            row_right_ff[r] <= row_right_in[r];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < vtbb_pkg::NUM_ROWS; r++) begin
         coef[r][0] = row_left_ff[r][vtbb_pkg::REG_BITS-1:vtbb_pkg::COEF_BITS];
         coef[r][1] = row_left_ff[r][vtbb_pkg::COEF_BITS-1:0];
         coef[r][2] = row_right_ff[r][vtbb_pkg::REG_BITS-1:vtbb_pkg::COEF_BITS];
         coef[r][3] = row_right_ff[r][vtbb_pkg::COEF_BITS-1:0];
      end
      for (int c = 0; c < 4; c++) begin
         p[c] = in_data[c*vtbb_pkg::COORD_BITS +: vtbb_pkg::COORD_BITS];
      end
      for (int r = 0; r < vtbb_pkg::NUM_ROWS; r++) begin
         for (int c = 0; c < 4; c++) begin
            prod_in[r][c] = vtbb_pkg::mul_s(p[c], coef[r][c]);
         end
         sum_in[r] = vtbb_pkg::SUM_W'(prod_ff[r][0]) + vtbb_pkg::SUM_W'(prod_ff[r][1])
                   + vtbb_pkg::SUM_W'(prod_ff[r][2]) + vtbb_pkg::SUM_W'(prod_ff[r][3]);
      end
   end

   // stall the whole pipe only when the last stage cannot drain
   assign adv      = !(v2_ff && q_status.full);
   assign in_ready = adv;
   assign v1_in    = adv ? in_valid : v1_ff;
   assign v2_in    = adv ? v1_ff : v2_ff;
   assign push     = v2_ff && !q_status.full;

   always_comb begin
      for (int r = 0; r < vtbb_pkg::NUM_ROWS; r++) begin
         push_entry.coord[r] = vtbb_pkg::shift_sat(sum_ff[r]);
      end
      push_entry.last = last2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < vtbb_pkg::NUM_ROWS; r++) begin
            for (int c = 0; c < 4; c++) begin
               prod_ff[r][c] <= prod_in[r][c];
            end
            sum_ff[r] <= sum_in[r];
         end
         last1_ff <= in_last;
         last2_ff <= last1_ff;
      end
   end

endmodule

`default_nettype wire

/* rtl/vtbb_queue.sv */
// Short queue of transformed vertices between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module vtbb_queue (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               push,
   input  wire vtbb_pkg::entry_type          push_entry,
   input  wire                               pop,
   output vtbb_pkg::entry_type               pop_entry,
   output vtbb_pkg::queue_status_type        status
);

   vtbb_pkg::entry_type entry_ff [vtbb_pkg::QUEUE_DEPTH];

   logic [vtbb_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [vtbb_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [vtbb_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;

   assign status.full  = (count_ff == vtbb_pkg::QUEUE_CNT_BITS'(vtbb_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_entry    = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + vtbb_pkg::QUEUE_CNT_BITS'(push)
                    - vtbb_pkg::QUEUE_CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* rtl/vtbb_back.sv */
// Back end: running bounding box update and the registered result stage.
`timescale 1ns / 1ps
`default_nettype none

module vtbb_back (
   input  wire                              clock,
   input  wire                              reset,
   input  wire vtbb_pkg::queue_status_type  q_status,
   input  wire vtbb_pkg::entry_type         entry,
   output logic                             pop,
   output logic                             out_valid,
   input  wire                              out_ready,
   output logic [vtbb_pkg::RSP_DATA_W-1:0]  out_data,
   output logic                             out_box_valid
);

   localparam int CB = vtbb_pkg::COORD_BITS;

   logic                                      started_ff, started_in;
   logic [vtbb_pkg::NUM_AXES-1:0][CB-1:0]     lo_ff, lo_in, lo_n;
   logic [vtbb_pkg::NUM_AXES-1:0][CB-1:0]     hi_ff, hi_in, hi_n;
   logic [vtbb_pkg::NUM_AXES-1:0][CB-1:0]     box_min, box_ext;
   logic                                      rsp_valid_ff, rsp_valid_in;
   logic [vtbb_pkg::RSP_DATA_W-1:0]           rsp_data_ff, rsp_data_in;
   logic                                      rsp_box_ff;

   assign pop = !q_status.empty && (!rsp_valid_ff || out_ready);

   always_comb begin
      for (int a = 0; a < vtbb_pkg::NUM_AXES; a++) begin
         if (!started_ff) begin
            lo_n[a] = entry.coord[a];
            hi_n[a] = entry.coord[a];
         end else begin
            lo_n[a] = ($signed(entry.coord[a]) < $signed(lo_ff[a])) ? entry.coord[a] : lo_ff[a];
            hi_n[a] = ($signed(entry.coord[a]) > $signed(hi_ff[a])) ? entry.coord[a] : hi_ff[a];
         end
         box_min[a] = entry.last ? lo_n[a] : '0;
         box_ext[a] = entry.last ? hi_n[a] - lo_n[a] : '0;
      end
      started_in = started_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      if (pop) begin
         started_in = !entry.last;
         lo_in      = entry.last ? '0 : lo_n;
         hi_in      = entry.last ? '0 : hi_n;
      end
      rsp_data_in = vtbb_pkg::RSP_DATA_W'({box_ext[2], box_ext[1], box_ext[0],
                                           box_min[2], box_min[1], box_min[0],
                                           entry.coord[3], entry.coord[2],
                                           entry.coord[1], entry.coord[0]});
      rsp_valid_in = pop ? 1'b1 : (rsp_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         started_ff   <= started_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
         rsp_box_ff  <= entry.last;
      end
   end

   assign out_valid     = rsp_valid_ff;
   assign out_data      = rsp_data_ff;
   assign out_box_valid = rsp_box_ff;

endmodule

`default_nettype wire

/* rtl/vertex_transform_bounding_box.sv */
// Top level of the 4x4 vertex transform with running bounding box.
//
// Usage: write the eight matrix row halves through csr_we/csr_index/csr_data
// while no vertex is in flight; reset loads the identity matrix. Each req
// transaction carries one vertex (px,py,pz,pw) in req_tdata and the last-of-object
// flag in req_tlast. Each vertex yields exactly one rsp transaction: the
// transformed vertex, and on the last vertex of an object also the box minimum
// corner and extents, flagged by rsp_tuser; the box then clears.
// From req acceptance a vertex passes the two multiply/sum pipeline stages, the
// queue and the result register before the result can be taken. Throughput: one
// vertex per cycle while the queue is not full, set by the sixteen parallel
// multipliers feeding the pipeline.
// When rsp stalls, the result register holds, the back end stops popping, the
// four-entry queue fills and req_tready drops only once the queue is full.
// Reset is synchronous: it clears the pipeline valid flags, the queue, the box state
// and the result valid flag, and restores the identity matrix.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vertex_transform_bounding_box (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire [vtbb_pkg::REQ_DATA_W-1:0]    req_tdata,  // px, py, pz, pw
   input  wire                               req_tlast,  // last_vertex
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // tx, ty, tz, tw, box_min_x, box_min_y, box_min_z, box_width, box_height, box_depth
   output logic [vtbb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser,  // box_valid
   input  wire                               csr_we,
   input  wire [vtbb_pkg::IDX_BITS-1:0]      csr_index,
   input  wire [vtbb_pkg::REG_BITS-1:0]      csr_data
);

   vtbb_pkg::csr_write_type    csr;
   vtbb_pkg::queue_status_type q_status;
   vtbb_pkg::entry_type        push_entry;
   vtbb_pkg::entry_type        pop_entry;
   logic                       push;
   logic                       pop;
   logic                       box_fields_zero;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   vtbb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_data    (req_tdata),
      .in_last    (req_tlast),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   vtbb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   vtbb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .entry         (pop_entry),
      .pop           (pop),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_data      (rsp_tdata),
      .out_box_valid (rsp_tuser)
   );

   assign box_fields_zero = (rsp_tdata[vtbb_pkg::RSP_DATA_W-1:4*vtbb_pkg::COORD_BITS] == '0);

   `VTBB_ASSERT_IMPLY(a_no_overflow, clock, reset, push, !q_status.full)
   `VTBB_ASSERT_IMPLY(a_no_underflow, clock, reset, pop, !q_status.empty)
   `VTBB_ASSERT_IMPLY(a_stall_only_full, clock, reset, !req_tready, q_status.full)
   `VTBB_ASSERT_IMPLY(a_box_zero, clock, reset, rsp_tvalid && !rsp_tuser, box_fields_zero)
   `VTBB_ASSERT_NEXT(a_reset_idle, clock, reset, !rsp_tvalid)

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// Stream testbench for the vertex transform with bounding box: a predicted-results scoreboard.

module tb;

   localparam int CB    = vtbb_pkg::COORD_BITS;
   localparam int ACC_W = 2 * CB + 2;
   localparam logic signed [ACC_W-1:0] ACC_MAX = 66'sd2147483647;
   localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX - 1;

   localparam logic [CB-1:0] C_MIN  = 32'h8000_0000;
   localparam logic [CB-1:0] C_MAX  = 32'h7FFF_FFFF;
   localparam logic [CB-1:0] C_NEG1 = 32'hFFFF_FFFF;
   localparam logic [CB-1:0] C_ONE  = 32'h0001_0000;
   localparam logic [CB-1:0] C_MONE = 32'hFFFF_0000;

   typedef struct packed {
      logic [3:0][CB-1:0] coord;
      logic               last;
   } vertex_item_type;

   typedef struct packed {
      logic [9:0][CB-1:0] word;
      logic               box;
   } vertex_result_type;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [vtbb_pkg::REQ_DATA_W-1:0] req_tdata   = '0;
   logic                            req_tlast   = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [vtbb_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            csr_we      = 1'b0;
   logic [vtbb_pkg::IDX_BITS-1:0]   csr_index   = '0;
   logic [vtbb_pkg::REG_BITS-1:0]   csr_data    = '0;

   vertex_item_type   vertex_q[$];
   vertex_result_type result_q[$];

   logic [vtbb_pkg::REG_BITS-1:0] matrix_regs [8];
   logic [vtbb_pkg::REG_BITS-1:0] next_regs [8];

   logic                 box_open = 1'b0;
   logic signed [CB-1:0] box_lo [3] = '{0, 0, 0};
   logic signed [CB-1:0] box_hi [3] = '{0, 0, 0};

   int    mismatches    = 0;
   int    send_idle_pct = 0;
   int    recv_idle_pct = 0;
   int    hold_asks     = 0;
   int    hold_seen     = 0;
   int    stall_left    = 0;
   logic  req_fire      = 1'b0;
   string field_name [10] = '{"tx", "ty", "tz", "tw", "box_min_x", "box_min_y", "box_min_z",
                              "box_width", "box_height", "box_depth"};

   vertex_transform_bounding_box i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial forever #6 clock = ~clock;

   function automatic logic signed [CB-1:0] coef_at(input int r, input int c);
      logic [vtbb_pkg::REG_BITS-1:0] row_half;
      row_half = matrix_regs[2 * r + ((c >= 2) ? 1 : 0)];
      return (c % 2 == 1) ? row_half[31:0] : row_half[63:32];
   endfunction

   function automatic vertex_result_type transform_vertex(input vertex_item_type v);
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] pe;
      logic signed [ACC_W-1:0] ce;
      logic signed [CB-1:0]    t [4];
      vertex_result_type       res;
      res = '0;
      for (int r = 0; r < 4; r++) begin
         acc = '0;
         for (int c = 0; c < 4; c++) begin
            pe = $signed(v.coord[c]);
            ce = coef_at(r, c);
            acc = acc + pe * ce;
         end
         acc = acc >>> vtbb_pkg::FRAC_BITS;
         if (acc > ACC_MAX) begin
            t[r] = C_MAX;
         end else if (acc < ACC_MIN) begin
            t[r] = C_MIN;
         end else begin
            t[r] = acc[CB-1:0];
         end
         res.word[r] = t[r];
      end
      for (int a = 0; a < 3; a++) begin
         if (!box_open || t[a] < box_lo[a]) box_lo[a] = t[a];
         if (!box_open || t[a] > box_hi[a]) box_hi[a] = t[a];
      end
      box_open = 1'b1;
      if (v.last) begin
         res.box = 1'b1;
         for (int a = 0; a < 3; a++) begin
            res.word[4 + a] = box_lo[a];
            res.word[7 + a] = box_hi[a] - box_lo[a];
            box_lo[a] = '0;
            box_hi[a] = '0;
         end
         box_open = 1'b0;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [CB-1:0] want,
                                  input logic [CB-1:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("tb: mismatch in %s at %0t: expected %h, got %h", what, $time, want, got);
   endtask

   // sender
   always @(negedge clock) begin
      vertex_item_type v;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (vertex_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            v = vertex_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= v.coord;
            req_tlast  <= v.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         stall_left <= 150;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // check results, then predict from accepted vertices
   always @(posedge clock) begin
      vertex_result_type want;
      vertex_item_type   v;
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (result_q.size() == 0) begin
               report_mismatch("unexpected transaction", '0, rsp_tdata[31:0]);
            end else begin
               want = result_q.pop_front();
               if (rsp_tuser !== want.box)
                  report_mismatch("box_valid", CB'(want.box), CB'(rsp_tuser));
               for (int f = 0; f < 10; f++)
                  if (rsp_tdata[f*CB +: CB] !== want.word[f])
                     report_mismatch(field_name[f], want.word[f], rsp_tdata[f*CB +: CB]);
            end
         end
         if (req_tvalid && req_tready) begin
            v.coord = req_tdata;
            v.last  = req_tlast;
            result_q.insert(result_q.size(), transform_vertex(v));
         end
      end
   end

   task automatic add_vertex(input logic [CB-1:0] x, y, z, w, input logic last);
      vertex_item_type v;
      v.coord = {w, z, y, x};
      v.last  = last;
      vertex_q.insert(vertex_q.size(), v);
   endtask

   function automatic logic [CB-1:0] rand_coord();
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0: return C_MIN;
               1: return C_MAX;
               2: return C_NEG1;
               default: return '0;
            endcase
         end
         1, 2, 3, 4: return int'($urandom_range(0, 1 << 22)) - (1 << 21);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [CB-1:0] rand_coef();
      case ($urandom_range(7))
         0: begin
            case ($urandom_range(4))
               0: return C_MIN;
               1: return C_MAX;
               2: return C_ONE;
               3: return C_MONE;
               default: return '0;
            endcase
         end
         1, 2, 3, 4: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
         default: return $urandom();
      endcase
   endfunction

   task automatic add_random_runs(input int count);
      vertex_item_type v;
      int              n;
      int              len;
      n = 0;
      while (n < count) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
         for (int k = 0; k < len; k++) begin
            for (int j = 0; j < 4; j++)
               v.coord[j] = rand_coord();
            v.last = (k == len - 1);
            vertex_q.insert(vertex_q.size(), v);
         end
         n += len;
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (vertex_q.size() != 0 || req_tvalid || result_q.size() != 0);
      @(negedge clock);
   endtask

   task automatic load_matrix();
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= vtbb_pkg::IDX_BITS'(i);
         csr_data  <= next_regs[i];
         matrix_regs[i] = next_regs[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic fill_uniform(input logic [CB-1:0] c);
      for (int i = 0; i < 8; i++)
         next_regs[i] = {c, c};
   endtask

   task automatic start_phase(input int send_pct, input int recv_pct);
      @(posedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   initial begin
      fill_uniform('0);
      next_regs[vtbb_pkg::REG_ROW0_LEFT]  = {C_ONE, 32'h0};
      next_regs[vtbb_pkg::REG_ROW1_LEFT]  = {32'h0, C_ONE};
      next_regs[vtbb_pkg::REG_ROW2_RIGHT] = {C_ONE, 32'h0};
      next_regs[vtbb_pkg::REG_ROW3_RIGHT] = {32'h0, C_ONE};
      matrix_regs = next_regs;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // identity matrix from reset: extremes, single-vertex and flat runs
      start_phase(35, 71);
      add_vertex('0, '0, '0, '0, 1'b1);
      add_vertex(C_MAX, C_MIN, C_NEG1, C_ONE, 1'b1);
      add_vertex(C_MIN, C_MAX, 32'h1, C_MIN, 1'b0);
      add_vertex(C_MAX, C_MIN, '0, C_MAX, 1'b0);
      add_vertex(C_ONE, C_NEG1, C_MIN, '0, 1'b1);
      add_vertex(32'h5, 32'h5, 32'h5, 32'h5, 1'b0);
      add_vertex(32'h5, 32'h5, 32'h5, 32'h5, 1'b1);
      wait_drained();

      // largest coefficients: saturate both ways inside one run
      fill_uniform(C_MAX);
      load_matrix();
      start_phase(35, 71);
      add_vertex(C_MAX, C_MAX, C_MAX, C_MAX, 1'b0);
      add_vertex(C_MIN, C_MIN, C_MIN, C_MIN, 1'b0);
      add_vertex('0, '0, '0, '0, 1'b1);
      wait_drained();

      // most negative coefficients
      fill_uniform(C_MIN);
      load_matrix();
      start_phase(35, 71);
      add_vertex(C_MIN, C_MIN, C_MIN, C_MIN, 1'b0);
      add_vertex(C_MAX, C_MAX, C_MAX, C_MAX, 1'b0);
      add_vertex(C_NEG1, C_ONE, C_MIN, C_MAX, 1'b1);
      wait_drained();

      // negated reversal of the axes
      fill_uniform('0);
      next_regs[vtbb_pkg::REG_ROW0_RIGHT] = {32'h0, C_MONE};
      next_regs[vtbb_pkg::REG_ROW1_RIGHT] = {C_MONE, 32'h0};
      next_regs[vtbb_pkg::REG_ROW2_LEFT]  = {32'h0, C_MONE};
      next_regs[vtbb_pkg::REG_ROW3_LEFT]  = {C_MONE, 32'h0};
      load_matrix();
      start_phase(35, 71);
      add_vertex(C_MAX, C_MIN, C_ONE, C_NEG1, 1'b0);
      add_vertex(C_MIN, C_MAX, C_NEG1, C_ONE, 1'b1);
      wait_drained();

      for (int ph = 0; ph < 6; ph++) begin
         for (int i = 0; i < 8; i++)
            next_regs[i] = {rand_coef(), rand_coef()};
         load_matrix();
         if (ph < 2) begin
            start_phase(35, 71);
         end else if (ph < 4) begin
            start_phase(71, 35);
         end else begin
            start_phase(0, 0);
         end
         add_random_runs(190);
         if (ph == 4) begin
            repeat (3) @(posedge clock);
            hold_asks++;
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/vtbb_pkg.sv
rtl/vtbb_front.sv
rtl/vtbb_queue.sv
rtl/vtbb_back.sv
rtl/vertex_transform_bounding_box.sv
tb/tb.sv
